/* hdl/lsmvp_pkg.sv */
// Shared constants, codes and saturation helpers for the lane segment merge block.
// Used by the iterative divider and by the top level; depends on nothing.
package lsmvp_pkg;

  localparam int DIV_NW = 64;
  localparam int DIV_DW = 48;
  localparam int Q_SHIFT = 16;
  localparam int IN_CW = 11;

  localparam logic [1:0] FUNC_SEG = 2'd0;
  localparam logic [1:0] FUNC_EOF = 2'd1;
  localparam logic [1:0] FUNC_CLR = 2'd2;

  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_ROI_TOP        = 3'd2;
  localparam logic [2:0] REG_SLOPE_MIN      = 3'd3;
  localparam logic [2:0] REG_SLOPE_MAX      = 3'd4;
  localparam logic [2:0] REG_INTERCEPT_GATE = 3'd5;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* hdl/lane_segment_merge_vanishing_point.sv */
// Lane segment merge and vanishing point tracker; uses lsmvp_pkg and lsmvp_div.
// Classifies segments per side, sums endpoints and intersects the lane lines.
//
// One 64-step serial divider and one registered multiplier serve every computation under
// a small sequencer, and the block takes no new transaction while it works. A segment needs
// one division, then the intercept gate when that side is tracked, or no division when
// vertical; an end-of-frame transaction needs up to six divisions, and its result also waits
// while the previous result is still held at the output. Configuration writes are always
// taken and need no clearing pass.
module lane_segment_merge_vanishing_point #(
  parameter int MAX_SEGMENTS = 256,
  parameter int COORD_BITS   = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // seg_x_start, seg_y_start, seg_x_end, seg_y_end (11 bits each), zero padding.
  input  logic [47:0] s_axis_tdata,
  // func.
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vanish_x (16), vanish_y (16), right_slope (24), left_slope (24).
  output logic [79:0] m_axis_tdata,
  // right_kept, left_kept, no_solution.
  output logic [2:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [22:0] cfg_data_i
);
  import lsmvp_pkg::*;

  localparam int CUSE  = (COORD_BITS < IN_CW) ? COORD_BITS : IN_CW;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SUM_W = IN_CW + 1 + CNT_W;
  localparam logic [IN_CW-1:0] CMASK = IN_CW'((1 << CUSE) - 1);

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_SCHK = 5'd1,  ST_SDIV = 5'd2,  ST_SCLS = 5'd3;
  localparam logic [4:0] ST_SG1  = 5'd4,  ST_SG2  = 5'd5,  ST_SG3  = 5'd6,  ST_SADD = 5'd7;
  localparam logic [4:0] ST_ESIDE = 5'd8, ST_EKEEP = 5'd9, ST_ESDIV = 5'd10, ST_ESMUL = 5'd11;
  localparam logic [4:0] ST_EIST = 5'd12, ST_EIDIV = 5'd13, ST_ENEXT = 5'd14, ST_ECHK = 5'd15;
  localparam logic [4:0] ST_XM1  = 5'd16, ST_XM2  = 5'd17, ST_XM3  = 5'd18, ST_XDIV = 5'd19;
  localparam logic [4:0] ST_YST  = 5'd20, ST_YDIV = 5'd21, ST_OUT  = 5'd22;

  logic [4:0] state_q;

  logic [IN_CW-1:0] fw_q, roi_q;
  logic [22:0]      smin_q, smax_q;
  logic [15:0]      gate_q;

  logic signed [23:0] prev_q [2];
  logic signed [15:0] vx_prev_q, vy_prev_q;
  logic [CNT_W-1:0]   cnt_q [2];
  logic [SUM_W-1:0]   sums_q [2][4];

  logic [IN_CW-1:0]   xs_q, xe_q;
  logic [IN_CW:0]     ys_q, ye_q;
  logic signed [31:0] seg_slope_q;
  logic signed [63:0] pb_q, t_q, prod_q;
  logic               side_q;
  logic signed [23:0] sl_q [2];
  logic signed [31:0] icpt_q [2];
  logic               kept_q [2], ok_q [2];
  logic signed [33:0] num_q;
  logic signed [24:0] den_q;
  logic signed [15:0] x_q;
  logic               fail_q;

  logic               m_valid_q;
  logic [79:0]        m_data_q;
  logic [2:0]         m_user_q;

  logic                     div_start, div_busy, div_done;
  logic signed [DIV_NW-1:0] div_num, div_quot;
  logic signed [DIV_DW-1:0] div_den;

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] mul_p;

  logic               accept;
  logic [IN_CW-1:0]   in_xs, in_ys, in_xe, in_ye;
  logic signed [12:0] seg_dx, seg_dy;
  logic signed [31:0] smin_s, smax_s;
  logic [IN_CW-1:0]   split;
  logic               r_hit, l_hit;
  logic [CNT_W-1:0]   cnt_sel, hit_cnt;
  logic signed [23:0] prev_sel, hit_prev;
  logic signed [SUM_W:0] sum_dx, sum_dy;
  logic signed [63:0] gate_diff, gate_abs;
  logic               fail;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    in_xs    = s_axis_tdata[10:0] & CMASK;
    in_ys    = s_axis_tdata[21:11] & CMASK;
    in_xe    = s_axis_tdata[32:22] & CMASK;
    in_ye    = s_axis_tdata[43:33] & CMASK;
    seg_dx   = $signed({2'b0, xe_q}) - $signed({2'b0, xs_q});
    seg_dy   = $signed({1'b0, ye_q}) - $signed({1'b0, ys_q});
    smin_s   = $signed({9'b0, smin_q});
    smax_s   = $signed({9'b0, smax_q});
    split    = fw_q >> 1;
    r_hit    = (seg_slope_q >= smin_s) && (seg_slope_q <= smax_s) && (xs_q > split);
    l_hit    = (seg_slope_q <= -smin_s) && (seg_slope_q >= -smax_s) && (xs_q < split);
    hit_cnt  = l_hit ? cnt_q[1] : cnt_q[0];
    hit_prev = l_hit ? prev_q[1] : prev_q[0];
    cnt_sel  = cnt_q[side_q];
    prev_sel = prev_q[side_q];
    sum_dx   = $signed({1'b0, sums_q[side_q][2]}) - $signed({1'b0, sums_q[side_q][0]});
    sum_dy   = $signed({1'b0, sums_q[side_q][3]}) - $signed({1'b0, sums_q[side_q][1]});
    gate_diff = pb_q - (($signed(64'(ys_q)) <<< Q_SHIFT) - prod_q);
    gate_abs  = gate_diff[63] ? -gate_diff : gate_diff;
    fail = !ok_q[0] || !ok_q[1] || (sl_q[0] == 24'sd0) || (sl_q[1] == 24'sd0) ||
           (sl_q[0] == sl_q[1]);
  end

  always_comb begin
    mul_a = 34'(prev_sel);
    mul_b = 32'(vx_prev_q);
    unique case (state_q)
      ST_SG1:   mul_a = 34'(prev_q[side_q]);
      ST_SG2: begin
        mul_a = 34'(seg_slope_q);
        mul_b = $signed({21'b0, xs_q});
      end
      ST_ESMUL: begin
        mul_a = 34'(sl_q[side_q]);
        mul_b = $signed(32'(sums_q[side_q][0]));
      end
      ST_XM1: begin
        mul_a = num_q;
        mul_b = 32'(sl_q[0]);
      end
      ST_XM2: begin
        mul_a = 34'(icpt_q[0]);
        mul_b = 32'(den_q);
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = 64'(seg_dy) <<< Q_SHIFT;
    div_den   = 48'(seg_dx);
    unique case (state_q)
      ST_SCHK:  div_start = (seg_dx != 13'sd0);
      ST_ESIDE: begin
        div_start = !(cnt_sel == '0 && prev_sel != 24'sd0) && sum_dx != '0 && cnt_sel != '0;
        div_num   = 64'(sum_dy) <<< Q_SHIFT;
        div_den   = 48'(sum_dx);
      end
      ST_EIST: begin
        div_start = 1'b1;
        div_num   = ($signed(64'(sums_q[side_q][1])) <<< Q_SHIFT) - prod_q;
        div_den   = $signed(48'(cnt_sel));
      end
      ST_XM3: begin
        div_start = 1'b1;
        div_num   = 64'(num_q);
        div_den   = 48'(den_q);
      end
      ST_YST: begin
        div_start = 1'b1;
        div_num   = t_q;
        div_den   = 48'(den_q) <<< Q_SHIFT;
      end
      default: ;
    endcase
  end

  lsmvp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fw_q      <= 11'd640;
      roi_q     <= 11'd225;
      smin_q    <= 23'd19661;
      smax_q    <= 23'd196608;
      gate_q    <= 16'd128;
      prev_q    <= '{default: '0};
      vx_prev_q <= '0;
      vy_prev_q <= '0;
      cnt_q     <= '{default: '0};
      sums_q    <= '{default: '{default: '0}};
      side_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_FRAME_WIDTH:    fw_q   <= cfg_data_i[10:0];
          REG_FRAME_HEIGHT:   ;
          REG_ROI_TOP:        roi_q  <= cfg_data_i[10:0];
          REG_SLOPE_MIN:      smin_q <= cfg_data_i;
          REG_SLOPE_MAX:      smax_q <= cfg_data_i;
          REG_INTERCEPT_GATE: gate_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (s_axis_tuser)
              FUNC_SEG: state_q <= ST_SCHK;
              FUNC_EOF: begin
                side_q  <= 1'b0;
                state_q <= ST_ESIDE;
              end
              FUNC_CLR: prev_q <= '{default: '0};
              default: ;
            endcase
          end
        end
        ST_SCHK: state_q <= (seg_dx != 13'sd0) ? ST_SDIV : ST_IDLE;
        ST_SDIV: if (div_done) state_q <= ST_SCLS;
        ST_SCLS: begin
          side_q <= l_hit;
          if ((!r_hit && !l_hit) || hit_cnt >= CNT_W'(MAX_SEGMENTS)) state_q <= ST_IDLE;
          else if (hit_prev == 24'sd0) state_q <= ST_SADD;
          else state_q <= ST_SG1;
        end
        ST_SG1: state_q <= ST_SG2;
        ST_SG2: state_q <= ST_SG3;
        ST_SG3: state_q <= (gate_abs >= (64'(gate_q) << 12)) ? ST_IDLE : ST_SADD;
        ST_SADD: begin
          cnt_q[side_q]     <= cnt_q[side_q] + 1'b1;
          sums_q[side_q][0] <= sums_q[side_q][0] + SUM_W'(xs_q);
          sums_q[side_q][1] <= sums_q[side_q][1] + SUM_W'(ys_q);
          sums_q[side_q][2] <= sums_q[side_q][2] + SUM_W'(xe_q);
          sums_q[side_q][3] <= sums_q[side_q][3] + SUM_W'(ye_q);
          state_q <= ST_IDLE;
        end
        ST_ESIDE: begin
          if (cnt_sel == '0 && prev_sel != 24'sd0) state_q <= ST_EKEEP;
          else if (sum_dx == '0 || cnt_sel == '0) state_q <= ST_ENEXT;
          else state_q <= ST_ESDIV;
        end
        ST_EKEEP: state_q <= ST_ENEXT;
        ST_ESDIV: begin
          if (div_done) begin
            prev_q[side_q] <= sat24(div_quot);
            state_q        <= ST_ESMUL;
          end
        end
        ST_ESMUL: state_q <= ST_EIST;
        ST_EIST:  state_q <= ST_EIDIV;
        ST_EIDIV: if (div_done) state_q <= ST_ENEXT;
        ST_ENEXT: begin
          side_q  <= 1'b1;
          state_q <= side_q ? ST_ECHK : ST_ESIDE;
        end
        ST_ECHK: begin
          cnt_q   <= '{default: '0};
          sums_q  <= '{default: '{default: '0}};
          state_q <= fail ? ST_OUT : ST_XM1;
        end
        ST_XM1: state_q <= ST_XM2;
        ST_XM2: state_q <= ST_XM3;
        ST_XM3: state_q <= ST_XDIV;
        ST_XDIV: if (div_done) state_q <= ST_YST;
        ST_YST:  state_q <= ST_YDIV;
        ST_YDIV: begin
          if (div_done) begin
            vx_prev_q <= x_q;
            vy_prev_q <= sat16(div_quot);
            state_q   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(mul_p[63:0]);
    if (accept) begin
      xs_q <= in_xs;
      xe_q <= in_xe;
      ys_q <= (IN_CW+1)'(in_ys) + (IN_CW+1)'(roi_q);
      ye_q <= (IN_CW+1)'(in_ye) + (IN_CW+1)'(roi_q);
    end
    unique case (state_q)
      ST_SDIV: if (div_done) seg_slope_q <= div_quot[31:0];
      ST_SG2:  pb_q <= ($signed(64'(vy_prev_q)) <<< Q_SHIFT) - prod_q;
      ST_ESIDE: begin
        kept_q[side_q] <= (cnt_sel == '0 && prev_sel != 24'sd0);
        if (cnt_sel == '0 && prev_sel != 24'sd0) begin
          sl_q[side_q]   <= prev_sel;
          ok_q[side_q]   <= 1'b1;
        end else if (sum_dx == '0 || cnt_sel == '0) begin
          sl_q[side_q]   <= prev_sel;
          icpt_q[side_q] <= '0;
          ok_q[side_q]   <= 1'b0;
        end
      end
      ST_EKEEP: icpt_q[side_q] <= sat32(($signed(64'(vy_prev_q)) <<< Q_SHIFT) - prod_q);
      ST_ESDIV: begin
        if (div_done) begin
          sl_q[side_q] <= sat24(div_quot);
          ok_q[side_q] <= 1'b1;
        end
      end
      ST_EIDIV: if (div_done) icpt_q[side_q] <= sat32(div_quot);
      ST_ECHK: begin
        fail_q <= fail;
        num_q  <= 34'(icpt_q[1]) - 34'(icpt_q[0]);
        den_q  <= 25'(sl_q[0]) - 25'(sl_q[1]);
      end
      ST_XM2:  t_q <= prod_q;
      ST_XM3:  t_q <= t_q + prod_q;
      ST_XDIV: if (div_done) x_q <= sat16(div_quot);
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {sl_q[1], sl_q[0], vy_prev_q, vx_prev_q};
          m_user_q <= {fail_q, kept_q[1], kept_q[0]};
        end
      end
      default: ;
    endcase
  end

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_start && div_busy))
    else $error("divider started while busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CNT_W'(MAX_SEGMENTS)) && (cnt_q[1] <= CNT_W'(MAX_SEGMENTS)))
    else $error("segment count beyond limit");

  a_eof_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (cnt_q[0] == '0 && cnt_q[1] == '0))
    else $error("accumulators not cleared at end of frame");

endmodule

/* hdl/lsmvp_div.sv */
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on lsmvp_pkg for the operand widths.
module lsmvp_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [lsmvp_pkg::DIV_NW-1:0]  num_i,
  input  logic signed [lsmvp_pkg::DIV_DW-1:0]  den_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output logic signed [lsmvp_pkg::DIV_NW-1:0]  quot_o
);
  import lsmvp_pkg::*;

  localparam int STEP_W = $clog2(DIV_NW);

  logic              busy_q, done_q, neg_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] rem_q, dmag_q, rem_nx;
  logic [DIV_DW:0]   rem_sh, rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_NW-1]};
    rem_sub = rem_sh - {1'b0, dmag_q};
    ge      = rem_sh >= {1'b0, dmag_q};
    rem_nx  = ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[DIV_NW-1] ^ den_i[DIV_DW-1];
      quo_q  <= num_i[DIV_NW-1] ? DIV_NW'(-num_i) : DIV_NW'(num_i);
      dmag_q <= den_i[DIV_DW-1] ? DIV_DW'(-den_i) : DIV_DW'(den_i);
      rem_q  <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NW-2:0], ge};
      rem_q <= rem_nx;
    end
  end

endmodule
